// File: src/protobuf_message_field_extractor_core_assert.svh
`ifndef PROTOBUF_MESSAGE_FIELD_EXTRACTOR_CORE_ASSERT_SVH
`define PROTOBUF_MESSAGE_FIELD_EXTRACTOR_CORE_ASSERT_SVH

// condition that holds at every edge out of reset
`define PFE_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("pfe check failed");

// consequence that holds in the cycle after the antecedent
`define PFE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfe check failed");

`endif

// File: src/pfe_pkg.sv
package pfe_pkg;

   typedef enum logic [2:0] {
      O_TAG, O_VAL, O_LEN, O_SKIP, O_FIXED, O_NEST, O_FAIL
   } outer_phase_type;

   typedef enum logic [2:0] {
      I_IDLE, I_TAG, I_VAL, I_LEN, I_CAP, I_SKIP
   } inner_phase_type;

   typedef enum logic [1:0] {
      V_MORE, V_DONE, V_BAD
   } vstat_type;

   localparam logic [2:0] WT_VAR    = 3'd0;
   localparam logic [2:0] WT_FIX64  = 3'd1;
   localparam logic [2:0] WT_LEN    = 3'd2;
   localparam logic [2:0] WT_FIX32  = 3'd5;

   localparam logic [31:0] F_TYPE    = 32'd1;
   localparam logic [31:0] F_NESTED  = 32'd3;
   localparam logic [31:0] F_KEYACC  = 32'd3;
   localparam logic [31:0] F_VERSION = 32'd4;
   localparam logic [31:0] F_PUBKEY  = 32'd8;
   localparam logic [31:0] F_SIG     = 32'd9;

   localparam logic KIND_KEY     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [63:0] acc;
      logic [6:0]  shift;
      vstat_type   status;
   } vstep_type;

   typedef struct packed {
      logic        item_kind;
      logic        key_select;
      logic [6:0]  key_offset;
      logic [7:0]  key_byte;
      logic [31:0] message_type;
      logic        parse_failed;
      logic        nested_found;
      logic        key_accepted;
      logic        version_ok;
      logic [6:0]  public_key_length;
      logic [5:0]  signature_length;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic       key_valid;
      result_type key;
      logic       sum_valid;
      result_type sum;
   } result_pair_type;

   function automatic vstep_type varint_step(logic [63:0] acc, logic [6:0] shift,
                                             logic [7:0] b);
      vstep_type r;
      r.acc    = acc | ({57'd0, b[6:0]} << shift);
      r.shift  = shift;
      r.status = V_MORE;
      if (shift >= 7'd64) begin
         r.acc    = acc;
         r.status = V_BAD;
      end else if (!b[7]) begin
         r.status = V_DONE;
      end else begin
         r.shift = shift + 7'd7;
         if (r.shift >= 7'd64) r.status = V_BAD;
      end
      return r;
   endfunction

   function automatic logic [31:0] field_of(logic [63:0] tag);
      return tag[34:3];
   endfunction

endpackage

// File: src/pfe_decoder.sv
module pfe_decoder #(
   parameter int PUBLIC_KEY_CAP = 65,
   parameter int SIGNATURE_CAP  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_message,
   output pfe_pkg::result_pair_type results
);

   pfe_pkg::outer_phase_type oph_ff, oph_in;
   pfe_pkg::inner_phase_type iph_ff, iph_in;
   logic [63:0] oacc_ff, oacc_in, otag_ff, otag_in;
   logic [6:0]  osh_ff, osh_in;
   logic [31:0] orem_ff, orem_in;
   logic [63:0] iacc_ff, iacc_in, itag_ff, itag_in;
   logic [6:0]  ish_ff, ish_in;
   logic [31:0] irem_ff, irem_in;
   logic [6:0]  coff_ff, coff_in;
   logic [31:0] type_ff, type_in;
   logic        nested_ff, nested_in, kacc_ff, kacc_in, vacc_ff, vacc_in;
   logic [6:0]  pklen_ff, pklen_in, siglen_ff, siglen_in;

   pfe_pkg::vstep_type ovs, ivs;
   logic [31:0] avail;
   logic        failed;

   always_comb begin
      oph_in = oph_ff; oacc_in = oacc_ff; otag_in = otag_ff; osh_in = osh_ff;
      orem_in = orem_ff;
      iph_in = iph_ff; iacc_in = iacc_ff; itag_in = itag_ff; ish_in = ish_ff;
      irem_in = irem_ff; coff_in = coff_ff;
      type_in = type_ff; nested_in = nested_ff; kacc_in = kacc_ff; vacc_in = vacc_ff;
      pklen_in = pklen_ff; siglen_in = siglen_ff;
      results = '0;
      ovs = pfe_pkg::varint_step(oacc_ff, osh_ff, data_byte);
      ivs = pfe_pkg::varint_step(iacc_ff, ish_ff, data_byte);
      avail = orem_ff - 32'd1;
      failed = 1'b0;

      case (oph_ff)
         pfe_pkg::O_TAG: begin
            oacc_in = ovs.acc; osh_in = ovs.shift;
            if (ovs.status == pfe_pkg::V_BAD) begin
               oph_in = pfe_pkg::O_FAIL;
            end else if (ovs.status == pfe_pkg::V_DONE) begin
               otag_in = ovs.acc; oacc_in = '0; osh_in = '0;
               case (ovs.acc[2:0])
                  pfe_pkg::WT_VAR: oph_in = pfe_pkg::O_VAL;
                  pfe_pkg::WT_LEN: oph_in = pfe_pkg::O_LEN;
                  pfe_pkg::WT_FIX32: begin
                     oph_in = pfe_pkg::O_FIXED; orem_in = 32'd4;
                  end
                  pfe_pkg::WT_FIX64: begin
                     oph_in = pfe_pkg::O_FIXED; orem_in = 32'd8;
                  end
                  default: oph_in = pfe_pkg::O_FAIL;
               endcase
            end
         end
         pfe_pkg::O_VAL: begin
            oacc_in = ovs.acc; osh_in = ovs.shift;
            if (ovs.status == pfe_pkg::V_BAD) begin
               oph_in = pfe_pkg::O_FAIL;
            end else if (ovs.status == pfe_pkg::V_DONE) begin
               if (pfe_pkg::field_of(otag_ff) == pfe_pkg::F_TYPE) type_in = ovs.acc[31:0];
               oacc_in = '0; osh_in = '0; oph_in = pfe_pkg::O_TAG;
            end
         end
         pfe_pkg::O_LEN: begin
            oacc_in = ovs.acc; osh_in = ovs.shift;
            if (ovs.status == pfe_pkg::V_BAD) begin
               oph_in = pfe_pkg::O_FAIL;
            end else if (ovs.status == pfe_pkg::V_DONE) begin
               oacc_in = '0; osh_in = '0;
               if (ovs.acc[63:32] != 32'd0) begin
                  oph_in = pfe_pkg::O_FAIL;
               end else begin
                  orem_in = ovs.acc[31:0];
                  if (pfe_pkg::field_of(otag_ff) == pfe_pkg::F_NESTED) begin
                     nested_in = 1'b1; iacc_in = '0; ish_in = '0;
                     iph_in = (ovs.acc != 64'd0) ? pfe_pkg::I_TAG : pfe_pkg::I_IDLE;
                     oph_in = (ovs.acc != 64'd0) ? pfe_pkg::O_NEST : pfe_pkg::O_TAG;
                  end else begin
                     oph_in = (ovs.acc != 64'd0) ? pfe_pkg::O_SKIP : pfe_pkg::O_TAG;
                  end
               end
            end
         end
         pfe_pkg::O_SKIP, pfe_pkg::O_FIXED: begin
            orem_in = orem_ff - 32'd1;
            if (orem_ff == 32'd1) oph_in = pfe_pkg::O_TAG;
         end
         pfe_pkg::O_NEST: begin
            case (iph_ff)
               pfe_pkg::I_TAG: begin
                  iacc_in = ivs.acc; ish_in = ivs.shift;
                  if (ivs.status == pfe_pkg::V_BAD) begin
                     iph_in = pfe_pkg::I_IDLE;
                  end else if (ivs.status == pfe_pkg::V_DONE) begin
                     itag_in = ivs.acc; iacc_in = '0; ish_in = '0;
                     case (ivs.acc[2:0])
                        pfe_pkg::WT_VAR: iph_in = pfe_pkg::I_VAL;
                        pfe_pkg::WT_LEN: iph_in = pfe_pkg::I_LEN;
                        pfe_pkg::WT_FIX32: begin
                           iph_in = pfe_pkg::I_SKIP; irem_in = 32'd4;
                        end
                        pfe_pkg::WT_FIX64: begin
                           iph_in = pfe_pkg::I_SKIP; irem_in = 32'd8;
                        end
                        default: iph_in = pfe_pkg::I_IDLE;
                     endcase
                  end
               end
               pfe_pkg::I_VAL: begin
                  iacc_in = ivs.acc; ish_in = ivs.shift;
                  if (ivs.status == pfe_pkg::V_BAD) begin
                     iph_in = pfe_pkg::I_IDLE;
                  end else if (ivs.status == pfe_pkg::V_DONE) begin
                     if (pfe_pkg::field_of(itag_ff) == pfe_pkg::F_KEYACC)
                        kacc_in = (ivs.acc != 64'd0);
                     else if (pfe_pkg::field_of(itag_ff) == pfe_pkg::F_VERSION)
                        vacc_in = (ivs.acc != 64'd0);
                     iacc_in = '0; ish_in = '0; iph_in = pfe_pkg::I_TAG;
                  end
               end
               pfe_pkg::I_LEN: begin
                  iacc_in = ivs.acc; ish_in = ivs.shift;
                  if (ivs.status == pfe_pkg::V_BAD) begin
                     iph_in = pfe_pkg::I_IDLE;
                  end else if (ivs.status == pfe_pkg::V_DONE) begin
                     iacc_in = '0; ish_in = '0;
                     if (ivs.acc > {32'd0, avail}) begin
                        iph_in = pfe_pkg::I_IDLE;
                     end else begin
                        if (pfe_pkg::field_of(itag_ff) == pfe_pkg::F_PUBKEY &&
                            ivs.acc <= 64'(PUBLIC_KEY_CAP)) begin
                           pklen_in = ivs.acc[6:0];
                           iph_in = (ivs.acc != 64'd0) ? pfe_pkg::I_CAP : pfe_pkg::I_TAG;
                        end else if (pfe_pkg::field_of(itag_ff) == pfe_pkg::F_SIG &&
                                     ivs.acc <= 64'(SIGNATURE_CAP)) begin
                           siglen_in = ivs.acc[6:0];
                           iph_in = (ivs.acc != 64'd0) ? pfe_pkg::I_CAP : pfe_pkg::I_TAG;
                        end else begin
                           iph_in = (ivs.acc != 64'd0) ? pfe_pkg::I_SKIP : pfe_pkg::I_TAG;
                        end
                        irem_in = ivs.acc[31:0];
                        coff_in = '0;
                     end
                  end
               end
               pfe_pkg::I_CAP: begin
                  results.key_valid      = 1'b1;
                  results.key.item_kind  = pfe_pkg::KIND_KEY;
                  results.key.key_select = (pfe_pkg::field_of(itag_ff) == pfe_pkg::F_SIG);
                  results.key.key_offset = coff_ff;
                  results.key.key_byte   = data_byte;
                  results.key.last_of_run = !end_of_message;
                  coff_in = coff_ff + 7'd1;
                  irem_in = irem_ff - 32'd1;
                  if (irem_ff == 32'd1) iph_in = pfe_pkg::I_TAG;
               end
               pfe_pkg::I_SKIP: begin
                  irem_in = irem_ff - 32'd1;
                  if (irem_ff == 32'd1) iph_in = pfe_pkg::I_TAG;
               end
               default: ;
            endcase
            orem_in = orem_ff - 32'd1;
            if (orem_ff == 32'd1) begin
               oph_in = pfe_pkg::O_TAG; iph_in = pfe_pkg::I_IDLE;
               iacc_in = '0; ish_in = '0; irem_in = '0;
            end
         end
         default: ;
      endcase

      if (end_of_message) begin
         failed = oph_in == pfe_pkg::O_FAIL || oph_in == pfe_pkg::O_VAL ||
                  oph_in == pfe_pkg::O_LEN || oph_in == pfe_pkg::O_SKIP ||
                  oph_in == pfe_pkg::O_NEST || (oph_in == pfe_pkg::O_TAG && osh_in != 7'd0);
         results.sum_valid = 1'b1;
         results.sum.item_kind = pfe_pkg::KIND_SUMMARY;
         results.sum.last_of_run = 1'b1;
         if (failed) begin
            results.sum.message_type = 32'hFFFF_FFFF;
            results.sum.parse_failed = 1'b1;
         end else begin
            results.sum.message_type      = type_in;
            results.sum.nested_found      = nested_in;
            results.sum.key_accepted      = kacc_in;
            results.sum.version_ok        = vacc_in;
            results.sum.public_key_length = pklen_in;
            results.sum.signature_length  = siglen_in[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_message)) begin
         oph_ff <= pfe_pkg::O_TAG; oacc_ff <= '0; osh_ff <= '0; otag_ff <= '0;
         orem_ff <= '0;
         iph_ff <= pfe_pkg::I_IDLE; iacc_ff <= '0; ish_ff <= '0; itag_ff <= '0;
         irem_ff <= '0; coff_ff <= '0;
         type_ff <= 32'hFFFF_FFFF; nested_ff <= 1'b0; kacc_ff <= 1'b0;
         vacc_ff <= 1'b0; pklen_ff <= '0; siglen_ff <= '0;
      end else if (step) begin
         oph_ff <= oph_in; oacc_ff <= oacc_in; osh_ff <= osh_in; otag_ff <= otag_in;
         orem_ff <= orem_in;
         iph_ff <= iph_in; iacc_ff <= iacc_in; ish_ff <= ish_in; itag_ff <= itag_in;
         irem_ff <= irem_in; coff_ff <= coff_in;
         type_ff <= type_in; nested_ff <= nested_in; kacc_ff <= kacc_in;
         vacc_ff <= vacc_in; pklen_ff <= pklen_in; siglen_ff <= siglen_in;
      end
   end

endmodule

// File: src/pfe_out_buf.sv
module pfe_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  pfe_pkg::result_pair_type results,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pfe_pkg::result_type      out_item
);

   logic [1:0]          cnt_ff, cnt_in;
   pfe_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic                take;

   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot0_ff;
   assign take      = out_valid && out_ready;
   assign in_ready  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && out_ready);

   always_comb begin
      cnt_in = cnt_ff; slot0_in = slot0_ff; slot1_in = slot1_ff;
      if (take) begin
         cnt_in = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
      if (load) begin
         if (results.key_valid && results.sum_valid) begin
            slot0_in = results.key; slot1_in = results.sum; cnt_in = 2'd2;
         end else if (results.key_valid) begin
            slot0_in = results.key; cnt_in = 2'd1;
         end else if (results.sum_valid) begin
            slot0_in = results.sum; cnt_in = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// File: src/protobuf_message_field_extractor_core.sv
// Streaming protobuf field extractor.
// req channel: one message byte per word in req_tdata, req_tlast on the
// final byte of each message.
// rsp channel: captured public key / signature bytes (rsp_tuser[0] = 0,
// rsp_tuser[1] selects the field) and one summary word per message
// (rsp_tuser[0] = 1) with the type field, status flags and key lengths.
// rsp_tlast marks the last word caused by one request byte.
// Throughput: one byte per cycle while results are taken; a byte that yields
// a key byte and a summary together fills both result entries and stalls req.
// A byte's first result word shows on rsp in the cycle after it is accepted;
// the parse state and a two-entry result register sit between the channels.
// When rsp stalls, words hold in the result register and req_tready drops
// once the next byte could not be stored.
// Reset clears the parse state (type field -1) and drops pending results.
module protobuf_message_field_extractor_core #(
   parameter int PUBLIC_KEY_CAP = 65,
   parameter int SIGNATURE_CAP  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // key_offset, key_byte, message_type, parse_failed, nested_found,
   // key_accepted, version_ok, public_key_length, signature_length
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // item_kind, key_select
   output logic        rsp_tlast   // last_of_run
);

   pfe_pkg::result_pair_type results;
   pfe_pkg::result_type      item;
   logic                     step;

   assign step = req_tvalid && req_tready;

   pfe_decoder #(
      .PUBLIC_KEY_CAP(PUBLIC_KEY_CAP),
      .SIGNATURE_CAP (SIGNATURE_CAP)
   ) u_decoder (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (req_tdata),
      .end_of_message(req_tlast),
      .results       (results)
   );

   pfe_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .results  (results),
      .in_ready (req_tready),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_item (item)
   );

   assign rsp_tdata = {item.signature_length, item.public_key_length,
                       item.version_ok, item.key_accepted, item.nested_found,
                       item.parse_failed, item.message_type, item.key_byte,
                       item.key_offset};
   assign rsp_tuser = {item.key_select, item.item_kind};
   assign rsp_tlast = item.last_of_run;

endmodule

// File: src/pfe_checker.sv
`include "protobuf_message_field_extractor_core_assert.svh"

module pfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic fail_word, fail_clean;

   assign fail_word  = rsp_tvalid && rsp_tuser[0] && rsp_tdata[47];
   assign fail_clean = rsp_tdata[46:15] == 32'hFFFF_FFFF && rsp_tdata[63:48] == 16'd0 &&
                       rsp_tdata[14:0] == 15'd0 && rsp_tuser[1] == 1'b0;

   `PFE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `PFE_ASSERT_ALWAYS(a_summary_last, !(rsp_tvalid && rsp_tuser[0]) || rsp_tlast)
   `PFE_ASSERT_ALWAYS(a_key_clean, !(rsp_tvalid && !rsp_tuser[0]) || rsp_tdata[63:15] == 49'd0)
   `PFE_ASSERT_ALWAYS(a_fail_clean, !fail_word || fail_clean)

endmodule

bind protobuf_message_field_extractor_core pfe_checker u_pfe_checker (.*);

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int PUB_CAP = 65;
   localparam int SIG_CAP = 32;

   typedef logic [7:0] byte_list_type[$];
   typedef struct {
      logic [7:0] data;
      logic       last;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   protobuf_message_field_extractor_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   word_type            pending_words[$];
   pfe_pkg::result_type expected_results[$];
   int                  error_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   logic                recv_hold = 1'b0;
   int                  n_messages = 0, n_key_bytes = 0, n_summaries = 0, n_failed = 0;

   // decoder state
   pfe_pkg::outer_phase_type o_phase;
   logic [63:0]              o_acc, o_tag;
   logic [6:0]               o_shift;
   logic [31:0]              o_left;
   pfe_pkg::inner_phase_type i_phase;
   logic [63:0]              i_acc, i_tag;
   logic [6:0]               i_shift;
   logic [31:0]              i_left;
   logic [6:0]               cap_pos;
   logic [31:0]              type_field;
   logic                     f_nested, f_keyacc, f_version;
   logic [6:0]               pub_len, sig_len;

   task automatic clear_decoder();
      o_phase = pfe_pkg::O_TAG; o_acc = 0; o_shift = 0; o_tag = 0; o_left = 0;
      i_phase = pfe_pkg::I_IDLE; i_acc = 0; i_shift = 0; i_tag = 0; i_left = 0;
      cap_pos = 0; type_field = 32'hFFFF_FFFF;
      f_nested = 0; f_keyacc = 0; f_version = 0; pub_len = 0; sig_len = 0;
   endtask

   function automatic pfe_pkg::vstat_type varint_add(inout logic [63:0] acc,
                                                     inout logic [6:0] sh,
                                                     input logic [7:0] b);
      if (sh >= 7'd64) return pfe_pkg::V_BAD;
      acc = acc | ({57'd0, b[6:0]} << sh);
      if (!b[7]) return pfe_pkg::V_DONE;
      sh = sh + 7'd7;
      if (sh >= 7'd64) return pfe_pkg::V_BAD;
      return pfe_pkg::V_MORE;
   endfunction

   task automatic nested_byte(input logic [7:0] b, input logic [31:0] avail,
                              output logic got, output logic sel, output logic [6:0] off);
      pfe_pkg::vstat_type st;
      logic [63:0]        v;
      logic [31:0]        fnum;
      got = 0; sel = 0; off = 0;
      fnum = i_tag[34:3];
      case (i_phase)
         pfe_pkg::I_TAG: begin
            st = varint_add(i_acc, i_shift, b);
            if (st == pfe_pkg::V_BAD) i_phase = pfe_pkg::I_IDLE;
            else if (st == pfe_pkg::V_DONE) begin
               i_tag = i_acc; i_acc = 0; i_shift = 0;
               case (i_tag[2:0])
                  pfe_pkg::WT_VAR: i_phase = pfe_pkg::I_VAL;
                  pfe_pkg::WT_LEN: i_phase = pfe_pkg::I_LEN;
                  pfe_pkg::WT_FIX32: begin i_phase = pfe_pkg::I_SKIP; i_left = 4; end
                  pfe_pkg::WT_FIX64: begin i_phase = pfe_pkg::I_SKIP; i_left = 8; end
                  default: i_phase = pfe_pkg::I_IDLE;
               endcase
            end
         end
         pfe_pkg::I_VAL: begin
            st = varint_add(i_acc, i_shift, b);
            if (st == pfe_pkg::V_BAD) i_phase = pfe_pkg::I_IDLE;
            else if (st == pfe_pkg::V_DONE) begin
               if (fnum == pfe_pkg::F_KEYACC) f_keyacc = (i_acc != 0);
               else if (fnum == pfe_pkg::F_VERSION) f_version = (i_acc != 0);
               i_acc = 0; i_shift = 0; i_phase = pfe_pkg::I_TAG;
            end
         end
         pfe_pkg::I_LEN: begin
            st = varint_add(i_acc, i_shift, b);
            if (st == pfe_pkg::V_BAD) i_phase = pfe_pkg::I_IDLE;
            else if (st == pfe_pkg::V_DONE) begin
               v = i_acc; i_acc = 0; i_shift = 0;
               if (v > {32'd0, avail}) i_phase = pfe_pkg::I_IDLE;
               else begin
                  if (fnum == pfe_pkg::F_PUBKEY && v <= 64'(PUB_CAP)) begin
                     pub_len = v[6:0];
                     i_phase = (v != 0) ? pfe_pkg::I_CAP : pfe_pkg::I_TAG;
                  end else if (fnum == pfe_pkg::F_SIG && v <= 64'(SIG_CAP)) begin
                     sig_len = v[6:0];
                     i_phase = (v != 0) ? pfe_pkg::I_CAP : pfe_pkg::I_TAG;
                  end else
                     i_phase = (v != 0) ? pfe_pkg::I_SKIP : pfe_pkg::I_TAG;
                  i_left = v[31:0];
                  cap_pos = 0;
               end
            end
         end
         pfe_pkg::I_CAP: begin
            got = 1; sel = (fnum == pfe_pkg::F_SIG); off = cap_pos;
            cap_pos = cap_pos + 7'd1;
            i_left = i_left - 1;
            if (i_left == 0) i_phase = pfe_pkg::I_TAG;
         end
         pfe_pkg::I_SKIP: begin
            i_left = i_left - 1;
            if (i_left == 0) i_phase = pfe_pkg::I_TAG;
         end
         default: ;
      endcase
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eom);
      pfe_pkg::vstat_type  st;
      logic [63:0]         v;
      logic                got, sel, failed;
      logic [6:0]          off;
      pfe_pkg::result_type r;
      got = 0;
      case (o_phase)
         pfe_pkg::O_TAG: begin
            st = varint_add(o_acc, o_shift, b);
            if (st == pfe_pkg::V_BAD) o_phase = pfe_pkg::O_FAIL;
            else if (st == pfe_pkg::V_DONE) begin
               o_tag = o_acc; o_acc = 0; o_shift = 0;
               case (o_tag[2:0])
                  pfe_pkg::WT_VAR: o_phase = pfe_pkg::O_VAL;
                  pfe_pkg::WT_LEN: o_phase = pfe_pkg::O_LEN;
                  pfe_pkg::WT_FIX32: begin o_phase = pfe_pkg::O_FIXED; o_left = 4; end
                  pfe_pkg::WT_FIX64: begin o_phase = pfe_pkg::O_FIXED; o_left = 8; end
                  default: o_phase = pfe_pkg::O_FAIL;
               endcase
            end
         end
         pfe_pkg::O_VAL: begin
            st = varint_add(o_acc, o_shift, b);
            if (st == pfe_pkg::V_BAD) o_phase = pfe_pkg::O_FAIL;
            else if (st == pfe_pkg::V_DONE) begin
               if (o_tag[34:3] == pfe_pkg::F_TYPE) type_field = o_acc[31:0];
               o_acc = 0; o_shift = 0; o_phase = pfe_pkg::O_TAG;
            end
         end
         pfe_pkg::O_LEN: begin
            st = varint_add(o_acc, o_shift, b);
            if (st == pfe_pkg::V_BAD) o_phase = pfe_pkg::O_FAIL;
            else if (st == pfe_pkg::V_DONE) begin
               v = o_acc; o_acc = 0; o_shift = 0;
               if (v[63:32] != 0) o_phase = pfe_pkg::O_FAIL;
               else begin
                  o_left = v[31:0];
                  if (o_tag[34:3] == pfe_pkg::F_NESTED) begin
                     f_nested = 1; i_acc = 0; i_shift = 0;
                     i_phase = (v != 0) ? pfe_pkg::I_TAG : pfe_pkg::I_IDLE;
                     o_phase = (v != 0) ? pfe_pkg::O_NEST : pfe_pkg::O_TAG;
                  end else
                     o_phase = (v != 0) ? pfe_pkg::O_SKIP : pfe_pkg::O_TAG;
               end
            end
         end
         pfe_pkg::O_SKIP, pfe_pkg::O_FIXED: begin
            o_left = o_left - 1;
            if (o_left == 0) o_phase = pfe_pkg::O_TAG;
         end
         pfe_pkg::O_NEST: begin
            nested_byte(b, o_left - 32'd1, got, sel, off);
            o_left = o_left - 1;
            if (o_left == 0) begin
               o_phase = pfe_pkg::O_TAG; i_phase = pfe_pkg::I_IDLE;
               i_acc = 0; i_shift = 0; i_left = 0;
            end
         end
         default: ;
      endcase
      if (got) begin
         r = '0;
         r.item_kind = pfe_pkg::KIND_KEY; r.key_select = sel; r.key_offset = off;
         r.key_byte = b;
         r.last_of_run = !eom;
         expected_results.push_back(r);
      end
      if (eom) begin
         failed = o_phase inside {pfe_pkg::O_FAIL, pfe_pkg::O_VAL, pfe_pkg::O_LEN,
                                  pfe_pkg::O_SKIP, pfe_pkg::O_NEST} ||
                  (o_phase == pfe_pkg::O_TAG && o_shift != 0);
         r = '0;
         r.item_kind = pfe_pkg::KIND_SUMMARY;
         r.last_of_run = 1;
         if (failed) begin
            r.message_type = 32'hFFFF_FFFF; r.parse_failed = 1;
         end else begin
            r.message_type = type_field; r.nested_found = f_nested;
            r.key_accepted = f_keyacc; r.version_ok = f_version;
            r.public_key_length = pub_len; r.signature_length = sig_len[5:0];
         end
         expected_results.push_back(r);
         clear_decoder();
      end
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            void'(pending_words.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold
         end else if (pending_words.size() != 0 &&
                      $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_words[0].data;
            req_tlast  <= pending_words[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pfe_pkg::result_type g, w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g = '0;
         g.item_kind = rsp_tuser[0]; g.key_select = rsp_tuser[1];
         g.key_offset = rsp_tdata[6:0]; g.key_byte = rsp_tdata[14:7];
         g.message_type = rsp_tdata[46:15]; g.parse_failed = rsp_tdata[47];
         g.nested_found = rsp_tdata[48]; g.key_accepted = rsp_tdata[49];
         g.version_ok = rsp_tdata[50]; g.public_key_length = rsp_tdata[57:51];
         g.signature_length = rsp_tdata[63:58]; g.last_of_run = rsp_tlast;
         if (g.item_kind == pfe_pkg::KIND_KEY) n_key_bytes++;
         else begin
            n_summaries++;
            if (g.parse_failed) n_failed++;
         end
         if (expected_results.size() == 0) begin
            report("unexpected word", {rsp_tuser, rsp_tdata[61:0]}, 0);
         end else begin
            w = expected_results.pop_front();
            if (g.item_kind != w.item_kind) report("item_kind", g.item_kind, w.item_kind);
            if (g.key_select != w.key_select) report("key_select", g.key_select, w.key_select);
            if (g.key_offset != w.key_offset) report("key_offset", g.key_offset, w.key_offset);
            if (g.key_byte != w.key_byte) report("key_byte", g.key_byte, w.key_byte);
            if (g.message_type != w.message_type)
               report("message_type", g.message_type, w.message_type);
            if (g.parse_failed != w.parse_failed)
               report("parse_failed", g.parse_failed, w.parse_failed);
            if (g.nested_found != w.nested_found)
               report("nested_found", g.nested_found, w.nested_found);
            if (g.key_accepted != w.key_accepted)
               report("key_accepted", g.key_accepted, w.key_accepted);
            if (g.version_ok != w.version_ok)
               report("version_ok", g.version_ok, w.version_ok);
            if (g.public_key_length != w.public_key_length)
               report("public_key_length", g.public_key_length, w.public_key_length);
            if (g.signature_length != w.signature_length)
               report("signature_length", g.signature_length, w.signature_length);
            if (g.last_of_run != w.last_of_run)
               report("last_of_run", g.last_of_run, w.last_of_run);
         end
      end
      if (reset || recv_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // long receiver hold-off
   initial begin
      wait (recv_hold);
      repeat (400) @(posedge clock);
      recv_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   function automatic byte_list_type varint_bytes(logic [63:0] v);
      byte_list_type q;
      do begin
         q.push_back({(v >> 7) != 0, v[6:0]});
         v = v >> 7;
      end while (v != 0);
      return q;
   endfunction

   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v >> $urandom_range(0, 63);
   endfunction

   function automatic byte_list_type rand_bytes(int n);
      byte_list_type q;
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   function automatic byte_list_type tag_bytes(logic [31:0] fnum, logic [2:0] wt);
      return varint_bytes({29'd0, fnum, wt});
   endfunction

   function automatic int key_size(int cap);
      case ($urandom_range(0, 19))
         0: return cap;
         1: return cap + 1;
         default: return int'($urandom_range(0, 6));
      endcase
   endfunction

   function automatic byte_list_type nested_payload();
      byte_list_type q;
      int n;
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 9))
            0, 1: q = {q, tag_bytes(pfe_pkg::F_KEYACC, pfe_pkg::WT_VAR),
                       varint_bytes(64'($urandom_range(0, 1)))};
            2, 3: q = {q, tag_bytes(pfe_pkg::F_VERSION, pfe_pkg::WT_VAR),
                       varint_bytes(rand_value())};
            4, 5: begin
               n = key_size(PUB_CAP);
               q = {q, tag_bytes(pfe_pkg::F_PUBKEY, pfe_pkg::WT_LEN), varint_bytes(64'(n)),
                    rand_bytes(n)};
            end
            6: begin
               n = key_size(SIG_CAP);
               q = {q, tag_bytes(pfe_pkg::F_SIG, pfe_pkg::WT_LEN), varint_bytes(64'(n)),
                    rand_bytes(n)};
            end
            7: q = {q, tag_bytes($urandom_range(5, 20),
                                 $urandom_range(0, 1) ? pfe_pkg::WT_FIX32 : pfe_pkg::WT_FIX64),
                    rand_bytes($urandom_range(0, 8))};
            8: q = {q, tag_bytes($urandom_range(1, 12), 3'($urandom_range(0, 7))),
                    rand_bytes(2)};
            default: q = {q, tag_bytes(pfe_pkg::F_PUBKEY, pfe_pkg::WT_LEN),
                          varint_bytes(64'($urandom_range(3, 200)))};
         endcase
      end
      return q;
   endfunction

   function automatic byte_list_type random_message();
      byte_list_type q, p;
      int n;
      repeat ($urandom_range(1, 4)) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: q = {q, tag_bytes(pfe_pkg::F_TYPE, pfe_pkg::WT_VAR),
                             varint_bytes(rand_value())};
            4, 5, 6, 7, 8, 9: begin
               p = nested_payload();
               q = {q, tag_bytes(pfe_pkg::F_NESTED, pfe_pkg::WT_LEN),
                    varint_bytes(64'(p.size())), p};
            end
            10, 11: begin
               n = $urandom_range(0, 5);
               q = {q, tag_bytes($urandom_range(4, 300), pfe_pkg::WT_LEN),
                    varint_bytes(64'(n)), rand_bytes(n)};
            end
            12: q = {q, tag_bytes($urandom_range(2, 9), pfe_pkg::WT_FIX32), rand_bytes(4)};
            13: q = {q, tag_bytes($urandom_range(2, 9), pfe_pkg::WT_FIX64), rand_bytes(8)};
            14: q = {q, tag_bytes($urandom_range(2, 99), pfe_pkg::WT_VAR),
                     varint_bytes(rand_value())};
            15: q = {q, tag_bytes($urandom_range(1, 9), 3'd3 + 3'($urandom_range(0, 1)))};
            16: q = {q, tag_bytes($urandom_range(1, 9), 3'd6 + 3'($urandom_range(0, 1)))};
            default: q = {q, rand_bytes($urandom_range(1, 3))};
         endcase
      end
      // truncate now and then to end inside a field
      if ($urandom_range(0, 9) == 0 && q.size() > 1)
         q = q[0:$urandom_range(0, q.size() - 2)];
      return q;
   endfunction

   task automatic queue_message(input byte_list_type q);
      word_type w;
      foreach (q[i]) begin
         w.data = q[i];
         w.last = (i == q.size() - 1);
         pending_words.push_back(w);
      end
      n_messages++;
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || expected_results.size() != 0 || recv_hold)
         @(posedge clock);
   endtask

   initial begin
      int added, target;
      byte_list_type p;
      clear_decoder();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed messages
      queue_message({tag_bytes(pfe_pkg::F_TYPE, pfe_pkg::WT_VAR),
                     varint_bytes(64'hFFFF_FFFF_FFFF_FFFF)});
      queue_message({8'h08, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                     8'h80, 8'h81, 8'h00});
      queue_message({tag_bytes(pfe_pkg::F_TYPE, 3'd3)});
      queue_message({tag_bytes(5, pfe_pkg::WT_LEN), varint_bytes(64'h1_0000_0000)});
      queue_message({tag_bytes(pfe_pkg::F_NESTED, pfe_pkg::WT_LEN), 8'h00});
      queue_message({tag_bytes(5, pfe_pkg::WT_FIX64), 8'h11, 8'h22});
      queue_message({tag_bytes(5, pfe_pkg::WT_LEN), 8'h04, 8'h01});
      queue_message({8'h88});
      p = {tag_bytes(pfe_pkg::F_SIG, pfe_pkg::WT_LEN), 8'h02, 8'hFF, 8'h00,
           tag_bytes(pfe_pkg::F_KEYACC, pfe_pkg::WT_VAR), 8'h01,
           tag_bytes(pfe_pkg::F_PUBKEY, pfe_pkg::WT_LEN), 8'h09};
      queue_message({tag_bytes(pfe_pkg::F_NESTED, pfe_pkg::WT_LEN), varint_bytes(64'(p.size())),
                     p, tag_bytes(pfe_pkg::F_TYPE, pfe_pkg::WT_VAR), 8'h7F});
      queue_message({tag_bytes(pfe_pkg::F_NESTED, pfe_pkg::WT_LEN), 8'h03,
                     tag_bytes(9, pfe_pkg::WT_FIX32), 8'hAA, 8'h55});

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 82; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 82; end
            3: begin send_idle_pct = 37; recv_idle_pct = 37; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = (phase == 4) ? 60 : 200;
         added = 0;
         while (added < target) begin
            p = random_message();
            queue_message(p);
            added += p.size();
         end
         if (phase == 4) begin
            @(posedge clock);
            recv_hold <= 1'b1;
         end
      end
      drain();
      repeat (20) @(posedge clock);

      $display("tb: %0d messages, %0d key bytes, %0d summaries (%0d failed)",
               n_messages, n_key_bytes, n_summaries, n_failed);
      $display("tb: idle and stall mixes on both channels plus one long receiver hold");
      if (error_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
